// ===== src/mrac_pkg.sv =====
// shared types, constants and helpers for the adaptive controller
// no dependencies; used by mrac_mac and mrac_adaptive_controller_top
`default_nettype none

package mrac_pkg;

	localparam int NUM_STATES = 3;
	localparam int NUM_GAINS  = NUM_STATES + 1;
	localparam int IDX_W      = $clog2(NUM_GAINS);
	localparam int SENS_IW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

	localparam int Q_W     = 32;
	localparam int FRAC    = 16;
	localparam int OP_W    = Q_W + 1;
	localparam int PROD_W  = 2 * OP_W;
	localparam int ACC_W   = 80;
	localparam int SUM_W   = 52;
	localparam int DELTA_W = ACC_W - Q_W;
	localparam int TH_W    = 24;
	localparam int LIMIT_W = 31;

	localparam int CFG_IDX_W  = $clog2(NUM_STATES + 3);
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_RATE_STATE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_REF    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_SENS_BASE   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = CFG_IDX_W'(2 + NUM_STATES);

	localparam logic signed [Q_W-1:0] GAIN_ONE    = 32'sh0001_0000;
	localparam logic [LIMIT_W-1:0]    LIMIT_RESET = {LIMIT_W{1'b1}};

	localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W-Q_W){1'b0}}, 32'h7FFF_FFFF};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {{(SUM_W-Q_W){1'b1}}, 32'h8000_0000};

	typedef struct packed {
		logic signed [Q_W-1:0] plant_pos;
		logic signed [Q_W-1:0] plant_vel;
		logic signed [Q_W-1:0] plant_press;
		logic signed [Q_W-1:0] model_pos;
		logic signed [Q_W-1:0] model_vel;
		logic signed [Q_W-1:0] model_press;
		logic signed [Q_W-1:0] reference;
	} in_data_t;

	typedef struct packed {
		logic signed [Q_W-1:0] drive;
		logic signed [Q_W-1:0] gain_pos;
		logic signed [Q_W-1:0] gain_vel;
		logic signed [Q_W-1:0] gain_press;
		logic signed [Q_W-1:0] gain_ref;
	} out_data_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DRIVE,
		ST_SIGMA,
		ST_WAIT,
		ST_GAIN_T,
		ST_GAIN_L,
		ST_GAIN_H,
		ST_TAIL,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DRIVE,
		OP_SIGMA,
		OP_TPROD,
		OP_LOW,
		OP_HIGH
	} mac_op_t;

	typedef struct packed {
		mac_op_t          op;
		logic [IDX_W-1:0] idx;
		logic             last;
	} mac_tag_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		logic signed [ACC_W-1:0]  acc;
		mac_tag_t                 tag_s1;
		mac_tag_t                 tag_s2;
	} mac_stat_t;

	// saturate a wide sum to the signed 32-bit range
	function automatic logic signed [Q_W-1:0] sat_q16(input logic signed [SUM_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > SUM_MAX)
			r = SUM_MAX[Q_W-1:0];
		else if (v < SUM_MIN)
			r = SUM_MIN[Q_W-1:0];
		else
			r = v[Q_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/mrac_mac.sv =====
// shared multiply-accumulate unit: one 33x33 signed multiplier, registered
// product and an 80-bit accumulator steered by a tag that follows each product
`default_nettype none

module mrac_mac import mrac_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic signed [OP_W-1:0] op_a,
	input  logic signed [OP_W-1:0] op_b,
	input  mac_tag_t               issue,
	output mac_stat_t              stat
);

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_d;
	logic signed [ACC_W-1:0]  p16;
	logic signed [ACC_W-1:0]  pext;
	logic signed [ACC_W-1:0]  phi;
	mac_tag_t                 tag_s1;
	mac_tag_t                 tag_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		acc_q   <= acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '{op: OP_NONE, idx: '0, last: 1'b0};
			tag_s2 <= '{op: OP_NONE, idx: '0, last: 1'b0};
		end else begin
			tag_s1 <= issue;
			tag_s2 <= tag_s1;
		end
	end

	// floor of product over 2^16, and the high partial product of t*rate
	assign p16  = ACC_W'(prod_s1 >>> FRAC);
	assign pext = ACC_W'(prod_s1);
	assign phi  = $signed({prod_s1[ACC_W-TH_W-1:0], {TH_W{1'b0}}});

	always_comb begin
		case (tag_s1.op) inside
			OP_DRIVE, OP_SIGMA: begin
				if (tag_s1.idx == '0)
					acc_d = p16;
				else
					acc_d = acc_q + p16;
			end
			OP_LOW:  acc_d = pext;
			OP_HIGH: acc_d = acc_q + phi;
			default: acc_d = acc_q;
		endcase
	end

	assign stat = '{prod: prod_s1, acc: acc_q, tag_s1: tag_s1, tag_s2: tag_s2};

endmodule

`default_nettype wire

// ===== src/mrac_adaptive_controller_top.sv =====
// top level of the model-reference adaptive controller: config registers,
// gain state, sequencer and output register; uses mrac_pkg and mrac_mac
//
// usage: write the six configuration registers through cfg_wr_en/cfg_index/
// cfg_data while the block is idle (rates, the three P*B_p terms, drive
// limit). each input transaction carries plant state, model state and the
// reference; each produces exactly one output transaction with the clamped
// drive and the four gains as they stood before this sample's update.
// all products go through one shared 33x33 multiplier under a sequencer:
// drive terms, sigma terms, then three products per gain (x*sigma and two
// halves of t*rate). the output transaction becomes valid in the same
// cycle that in_ready returns, so the block takes no new sample until the
// last one is computed; the chain through the multiplier and the
// sigma-to-gain dependency set how long each sample takes.
// the finished result sits in an output register; a stalled receiver lets
// the next sample be taken and computed, and that sample waits for the
// register before the block goes idle again.
// reset clears gains to 0 (feed-forward gain to 1.0), rates and sensitivity
// terms to 0 and the drive limit to its maximum; no output is pending.
`default_nettype none

module mrac_adaptive_controller_top import mrac_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_data_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_data_t             out_data
);

	state_t                   state_q;
	state_t                   state_d;
	logic [IDX_W-1:0]         idx_q;
	logic [IDX_W-1:0]         idx_d;

	logic [Q_W-1:0]           rate_state_q;
	logic [Q_W-1:0]           rate_ref_q;
	logic signed [Q_W-1:0]    sens_q [NUM_STATES];
	logic [LIMIT_W-1:0]       limit_q;
	logic [SENS_IW-1:0]       cfg_sens_sel;

	logic signed [Q_W-1:0]    gain_q [NUM_GAINS];
	in_data_t                 in_q;
	logic signed [Q_W-1:0]    xv [NUM_GAINS];
	logic signed [Q_W-1:0]    mv [NUM_STATES];
	logic signed [Q_W-1:0]    sigma_q;
	logic signed [TH_W-1:0]   th_q;
	out_data_t                res_q;
	out_data_t                out_q;
	logic                     out_valid_q;

	logic                     accept;
	logic                     finish_go;
	logic [Q_W-1:0]           rate_sel;
	logic signed [OP_W-1:0]   op_a;
	logic signed [OP_W-1:0]   op_b;
	mac_tag_t                 issue;
	mac_stat_t                mst;

	logic signed [SUM_W-1:0]  dsum;
	logic signed [SUM_W-1:0]  lim;
	logic signed [SUM_W-1:0]  lim_neg;
	logic signed [Q_W-1:0]    drive_clamped;
	logic signed [DELTA_W-1:0] delta;
	logic signed [SUM_W-1:0]  gain_diff;
	logic signed [Q_W-1:0]    gain_new;
	logic                     drive_cap;
	logic                     sigma_cap;
	logic                     gain_wr;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- configuration ----------------
	assign cfg_sens_sel = SENS_IW'(cfg_index - CFG_SENS_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_state_q <= '0;
			rate_ref_q   <= '0;
			limit_q      <= LIMIT_RESET;
			for (int i = 0; i < NUM_STATES; i++)
				sens_q[i] <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_RATE_STATE)
				rate_state_q <= cfg_data;
			else if (cfg_index == CFG_RATE_REF)
				rate_ref_q <= cfg_data;
			else if (cfg_index >= CFG_SENS_BASE && cfg_index < CFG_DRIVE_LIMIT)
				sens_q[cfg_sens_sel] <= $signed(cfg_data);
			else if (cfg_index == CFG_DRIVE_LIMIT)
				limit_q <= cfg_data[LIMIT_W-1:0];
		end
	end

	// ---------------- sample registers ----------------
	always_ff @(posedge clk) begin
		if (accept)
			in_q <= in_data;
	end

	// state vector with the reference as its last entry
	assign xv[0]          = in_q.plant_pos;
	assign xv[1]          = in_q.plant_vel;
	assign xv[2]          = in_q.plant_press;
	assign xv[NUM_STATES] = in_q.reference;
	assign mv[0]          = in_q.model_pos;
	assign mv[1]          = in_q.model_vel;
	assign mv[2]          = in_q.model_press;

	// ---------------- shared multiplier ----------------
	mrac_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op_a   (op_a),
		.op_b   (op_b),
		.issue  (issue),
		.stat   (mst)
	);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign rate_sel  = (idx_q == IDX_W'(NUM_STATES)) ? rate_ref_q : rate_state_q;
	assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		op_a    = '0;
		op_b    = '0;
		issue   = '{op: OP_NONE, idx: idx_q, last: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DRIVE;
					idx_d   = '0;
				end
			end
			ST_DRIVE: begin
				op_a     = OP_W'(gain_q[idx_q]);
				op_b     = OP_W'(xv[idx_q]);
				issue.op = OP_DRIVE;
				if (idx_q == IDX_W'(NUM_STATES)) begin
					state_d = ST_SIGMA;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_SIGMA: begin
				op_a       = OP_W'(xv[idx_q]) - OP_W'(mv[idx_q[SENS_IW-1:0]]);
				op_b       = OP_W'(sens_q[idx_q[SENS_IW-1:0]]);
				issue.op   = OP_SIGMA;
				issue.last = (idx_q == IDX_W'(NUM_STATES - 1));
				if (idx_q == IDX_W'(NUM_STATES - 1)) begin
					state_d = ST_WAIT;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_WAIT: begin
				if (sigma_cap)
					state_d = ST_GAIN_T;
			end
			ST_GAIN_T: begin
				op_a     = OP_W'(xv[idx_q]);
				op_b     = OP_W'(sigma_q);
				issue.op = OP_TPROD;
				state_d  = ST_GAIN_L;
			end
			ST_GAIN_L: begin
				// low 24 bits of t come straight off the product register
				op_a     = $signed({{(OP_W-TH_W){1'b0}}, mst.prod[FRAC+TH_W-1:FRAC]});
				op_b     = $signed({1'b0, rate_sel});
				issue.op = OP_LOW;
				state_d  = ST_GAIN_H;
			end
			ST_GAIN_H: begin
				op_a     = OP_W'(th_q);
				op_b     = $signed({1'b0, rate_sel});
				issue.op = OP_HIGH;
				if (idx_q == IDX_W'(NUM_STATES)) begin
					state_d = ST_TAIL;
				end else begin
					state_d = ST_GAIN_T;
					idx_d   = idx_q + 1'b1;
				end
			end
			ST_TAIL: begin
				if (gain_wr && mst.tag_s2.idx == IDX_W'(NUM_STATES))
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (finish_go)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- result forming ----------------
	assign drive_cap = (mst.tag_s1.op == OP_SIGMA) && (mst.tag_s1.idx == '0);
	assign sigma_cap = (mst.tag_s2.op == OP_SIGMA) && mst.tag_s2.last;
	assign gain_wr   = (mst.tag_s2.op == OP_HIGH);

	assign dsum    = $signed(mst.acc[SUM_W-1:0]);
	assign lim     = $signed({{(SUM_W-LIMIT_W){1'b0}}, limit_q});
	assign lim_neg = -lim;

	always_comb begin
		if (dsum > lim)
			drive_clamped = lim[Q_W-1:0];
		else if (dsum < lim_neg)
			drive_clamped = lim_neg[Q_W-1:0];
		else
			drive_clamped = dsum[Q_W-1:0];
	end

	// delta = floor(t * rate / 2^32)
	assign delta     = $signed(mst.acc[ACC_W-1:Q_W]);
	assign gain_diff = SUM_W'(gain_q[mst.tag_s2.idx]) - SUM_W'(delta);
	assign gain_new  = sat_q16(gain_diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_GAINS; i++)
				gain_q[i] <= (i == NUM_STATES) ? GAIN_ONE : '0;
		end else if (gain_wr) begin
			gain_q[mst.tag_s2.idx] <= gain_new;
		end
	end

	always_ff @(posedge clk) begin
		if (sigma_cap)
			sigma_q <= sat_q16(dsum);
		if (state_q == ST_GAIN_L)
			th_q <= mst.prod[FRAC+2*TH_W-1:FRAC+TH_W];
		if (accept) begin
			res_q.gain_pos   <= gain_q[0];
			res_q.gain_vel   <= gain_q[1];
			res_q.gain_press <= gain_q[2];
			res_q.gain_ref   <= gain_q[NUM_STATES];
		end
		if (drive_cap)
			res_q.drive <= drive_clamped;
		if (finish_go)
			out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (finish_go)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// ---------------- checks ----------------
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("block still ready after taking a sample");

	a_gain_write_in_item: assert property (@(posedge clk) disable iff (!arst_n)
		gain_wr |-> (state_q != ST_IDLE))
		else $error("gain written while idle");

	a_pipe_empty_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (mst.tag_s1.op == OP_NONE && mst.tag_s2.op == OP_NONE))
		else $error("multiplier pipeline not drained at finish");

	a_drive_capture_phase: assert property (@(posedge clk) disable iff (!arst_n)
		drive_cap |-> (state_q == ST_SIGMA || state_q == ST_WAIT))
		else $error("drive captured outside the sigma phase");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench for mrac_adaptive_controller_top
// a directed table and random phases are checked against table results or a bit-exact predictor
// depends on mrac_pkg and the controller rtl

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mrac_pkg::*;

	localparam int          N_DIR        = 23;
	localparam int          N_PHASES     = 8;
	localparam int          PHASE_ITEMS  = 92;
	localparam int          KEEP         = -1;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int          TAIL_CYCLES  = 30;

	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [Q_W-1:0] Q_ONE = GAIN_ONE;

	typedef logic signed [95:0] wide_t;
	typedef logic [CFG_DATA_W-1:0] reg_set_t [NUM_STATES+3];

	typedef struct {
		int        setting;
		in_data_t  stim;
		bit        typed;
		out_data_t want;
	} vec_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	in_data_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_data_t             out_data;

	// predictor copy of the controller state and registers
	logic signed [Q_W-1:0]  gain_st [NUM_STATES] = '{default: '0};
	logic signed [Q_W-1:0]  gain_ff = GAIN_ONE;
	logic [31:0]            rate_st = '0;
	logic [31:0]            rate_ff = '0;
	logic signed [Q_W-1:0]  sens_q [NUM_STATES] = '{default: '0};
	logic [LIMIT_W-1:0]     drive_lim = LIMIT_RESET;

	out_data_t   pending_results [$];
	int unsigned err_cnt = 0;
	int unsigned res_cnt = 0;
	bit          no_gaps = 1'b0;

	// register order: state rate, ref rate, three sensitivity terms, drive limit
	reg_set_t presets [5] = '{
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
			32'h7FFF_FFFF},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h0000_0000},
		'{32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001,
			32'hFFFF_FFFF},
		'{32'h0100_0000, 32'h0080_0000, 32'h0002_0000, 32'h0000_8000, 32'hFFFF_C000,
			32'h000A_0000},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h0000_0001}
	};

	// in: plant pos/vel/press, model pos/vel/press, reference
	// out: drive, gain pos/vel/press, gain ref
	vec_t dir_tab [N_DIR] = '{
		'{0, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{32'h0, 32'h0, 32'h0, 32'h0, Q_ONE}},
		'{KEEP, '{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX}, 1'b1,
			'{Q_MAX, 32'h0, 32'h0, 32'h0, Q_ONE}},
		// most negative reference clamps to minus the limit
		'{KEEP, '{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN}, 1'b1,
			'{32'h8000_0001, 32'h0, 32'h0, 32'h0, Q_ONE}},
		'{KEEP, '{32'h1, 32'hFFFF_FFFF, Q_MAX, 32'hFFFF_FFFF, 32'h1, Q_MIN, 32'h1}, 1'b1,
			'{32'h1, 32'h0, 32'h0, 32'h0, Q_ONE}},
		'{KEEP, '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF}, 1'b1,
			'{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, Q_ONE}},
		'{KEEP, '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555, 32'h0003_8000}, 1'b1,
			'{32'h0003_8000, 32'h0, 32'h0, 32'h0, Q_ONE}},
		'{KEEP, '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0, 32'h0, 32'h0,
			32'hFFFE_8000}, 1'b1,
			'{32'hFFFE_8000, 32'h0, 32'h0, 32'h0, Q_ONE}},
		// zero drive limit forces drive to zero, gains untouched so far
		'{1, '{Q_ONE, Q_ONE, Q_ONE, 32'h0, 32'h0, 32'h0, Q_ONE}, 1'b1,
			'{32'h0, 32'h0, 32'h0, 32'h0, Q_ONE}},
		'{KEEP, '{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX}, 1'b0, '{default: '0}},
		'{KEEP, '{Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN}, 1'b0, '{default: '0}},
		'{KEEP, '{32'h0002_4000, 32'hFFFD_0000, 32'h0000_0100, 32'h0001_0000,
			32'hFFFE_0000, 32'h0, 32'h0005_0000}, 1'b0, '{default: '0}},
		'{2, '{32'h0002_0000, 32'hFFFD_0000, 32'h0000_8000, 32'h0, 32'h0, 32'h0, Q_ONE},
			1'b0, '{default: '0}},
		'{KEEP, '{Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX}, 1'b0, '{default: '0}},
		'{KEEP, '{32'h0000_0010, 32'hFFFF_FFF0, 32'h0000_1000, 32'h0000_0008,
			32'hFFFF_FFF8, 32'h0, 32'hFFFF_0000}, 1'b0, '{default: '0}},
		'{3, '{Q_ONE, 32'h0000_8000, 32'hFFFF_0000, 32'h0000_8000, 32'h0, 32'h0,
			32'h0002_0000}, 1'b0, '{default: '0}},
		'{KEEP, '{32'h0003_0000, Q_ONE, 32'h0, Q_ONE, 32'h0, 32'h0, 32'h0004_0000},
			1'b0, '{default: '0}},
		'{KEEP, '{32'h0014_0000, 32'hFFF6_0000, 32'h0008_0000, 32'h0, 32'h0, 32'h0,
			32'h000C_0000}, 1'b0, '{default: '0}},
		'{KEEP, '{32'hFFEC_0000, 32'h000A_0000, 32'hFFF8_0000, 32'h0, 32'h0, 32'h0,
			32'hFFF4_0000}, 1'b0, '{default: '0}},
		'{KEEP, '{32'h0002_8000, 32'h0002_0000, 32'h0001_8000, 32'h0002_0000,
			32'h0002_0000, Q_ONE, 32'h0003_0000}, 1'b0, '{default: '0}},
		'{4, '{Q_ONE, Q_ONE, Q_ONE, 32'h0, 32'h0, 32'h0, Q_ONE}, 1'b0, '{default: '0}},
		'{KEEP, '{Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX}, 1'b0, '{default: '0}},
		'{KEEP, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '{default: '0}},
		'{KEEP, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
			32'hFFFF_FFFF}, 1'b0, '{default: '0}}
	};

	mrac_adaptive_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Q16.16 product, floored
	function automatic wide_t q16_mul(wide_t a, wide_t b);
		return (a * b) >>> FRAC;
	endfunction

	function automatic logic signed [Q_W-1:0] clip32(wide_t v);
		if (v > Q_MAX)
			return Q_MAX;
		if (v < Q_MIN)
			return Q_MIN;
		return v[Q_W-1:0];
	endfunction

	// floor(t * rate / 2^32) with rate as unsigned Q0.32
	function automatic wide_t rate_scale(wide_t t, logic [31:0] rate);
		wide_t g;
		g = '0;
		g[31:0] = rate;
		return (t * g) >>> 32;
	endfunction

	// returns this sample's result and advances the gains one step
	function automatic out_data_t ctrl_predict(in_data_t d);
		wide_t     x [NUM_STATES];
		wide_t     m [NUM_STATES];
		wide_t     r, acc, sig, lim;
		out_data_t o;
		x[0] = $signed(d.plant_pos);
		x[1] = $signed(d.plant_vel);
		x[2] = $signed(d.plant_press);
		m[0] = $signed(d.model_pos);
		m[1] = $signed(d.model_vel);
		m[2] = $signed(d.model_press);
		r = $signed(d.reference);
		acc = q16_mul(gain_ff, r);
		sig = '0;
		for (int i = 0; i < NUM_STATES; i++) begin
			acc += q16_mul(gain_st[i], x[i]);
			sig += q16_mul(x[i] - m[i], sens_q[i]);
		end
		lim = '0;
		lim[LIMIT_W-1:0] = drive_lim;
		if (acc > lim)
			acc = lim;
		else if (acc < -lim)
			acc = -lim;
		o.drive = acc[Q_W-1:0];
		o.gain_pos = gain_st[0];
		o.gain_vel = gain_st[1];
		o.gain_press = gain_st[2];
		o.gain_ref = gain_ff;
		sig = clip32(sig);
		for (int i = 0; i < NUM_STATES; i++)
			gain_st[i] = clip32(gain_st[i] - rate_scale(q16_mul(x[i], sig), rate_st));
		gain_ff = clip32(gain_ff - rate_scale(q16_mul(r, sig), rate_ff));
		return o;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned p;
		if (no_gaps)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 88)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic signed [Q_W-1:0] rand_q16();
		case ($urandom_range(0, 9))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3, 4: return $urandom;
			default: return $signed($urandom) >>> $urandom_range(6, 22);
		endcase
	endfunction

	// model state mostly tracks the plant so sigma stays in a useful range
	function automatic logic signed [Q_W-1:0] near_q16(logic signed [Q_W-1:0] p);
		if ($urandom_range(0, 3) == 0)
			return rand_q16();
		return p - ($signed($urandom) >>> $urandom_range(10, 28));
	endfunction

	function automatic logic [31:0] rand_rate();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom >> $urandom_range(4, 30);
		endcase
	endfunction

	task automatic report_error(string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	task automatic cmp_field(string name, logic [Q_W-1:0] got, logic [Q_W-1:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s: got %h, want %h", res_cnt, name, got, want));
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == CFG_RATE_STATE)
			rate_st = val;
		else if (idx == CFG_RATE_REF)
			rate_ff = val;
		else if (idx >= CFG_SENS_BASE && idx < CFG_DRIVE_LIMIT)
			sens_q[idx - CFG_SENS_BASE] = val;
		else if (idx == CFG_DRIVE_LIMIT)
			drive_lim = val[LIMIT_W-1:0];
	endtask

	// unused indexes get junk, which must be dropped
	task automatic apply_setting(reg_set_t s);
		wait_all_results();
		repeat (2) @(posedge clk);
		for (int k = 0; k < 2**CFG_IDX_W; k++)
			cfg_write(CFG_IDX_W'(k), (k < NUM_STATES + 3) ? s[k] : $urandom);
		cfg_wr_en <= 1'b0;
	endtask

	// leaves in_valid high after the transaction; the next call lowers it or reuses it
	task automatic send_sample(in_data_t d, bit typed, out_data_t want);
		out_data_t   pred;
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		do
			@(posedge clk);
		while (!in_ready);
		pred = ctrl_predict(d);
		pending_results.push_back(typed ? want : pred);
	endtask

	// receiver: bursts of ready broken by stalls
	initial begin
		bit          rx_on;
		int unsigned rx_left;
		rx_on = 1'b0;
		rx_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_left != 0) begin
				rx_left--;
			end else begin
				rx_on = !rx_on;
				rx_left = rx_on ? $urandom_range(1, 30) : pick_gap();
			end
			out_ready <= rx_on || no_gaps;
		end
	end

	always @(posedge clk) begin
		out_data_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_error($sformatf("result %0d arrived with none expected", res_cnt));
			end else begin
				want = pending_results.pop_front();
				cmp_field("drive", out_data.drive, want.drive);
				cmp_field("gain_pos", out_data.gain_pos, want.gain_pos);
				cmp_field("gain_vel", out_data.gain_vel, want.gain_vel);
				cmp_field("gain_press", out_data.gain_press, want.gain_press);
				cmp_field("gain_ref", out_data.gain_ref, want.gain_ref);
			end
			res_cnt++;
		end
	end

	// watchdog on cycles with no transaction on either side
	int unsigned idle_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		reg_set_t    rs;
		in_data_t    d;
		int unsigned pause_at;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			if (dir_tab[i].setting != KEEP)
				apply_setting(presets[dir_tab[i].setting]);
			send_sample(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			rs[CFG_RATE_STATE] = rand_rate();
			rs[CFG_RATE_REF] = rand_rate();
			for (int k = 0; k < NUM_STATES; k++)
				rs[CFG_SENS_BASE + k] = ($urandom_range(0, 7) == 0) ? '0 :
					$signed($urandom) >>> $urandom_range(8, 31);
			case ($urandom_range(0, 4))
				0: rs[CFG_DRIVE_LIMIT] = '0;
				1: rs[CFG_DRIVE_LIMIT] = $urandom;
				2: rs[CFG_DRIVE_LIMIT] = 32'hFFFF_FFFF;
				default: rs[CFG_DRIVE_LIMIT] = $urandom >> $urandom_range(8, 16);
			endcase
			apply_setting(rs);
			no_gaps = ($urandom_range(0, 3) == 0);
			pause_at = $urandom_range(10, PHASE_ITEMS - 10);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// sender holds off until the pipeline has fully drained
				if (n == pause_at)
					wait_all_results();
				d.plant_pos = rand_q16();
				d.plant_vel = rand_q16();
				d.plant_press = rand_q16();
				d.model_pos = near_q16(d.plant_pos);
				d.model_vel = near_q16(d.plant_vel);
				d.model_press = near_q16(d.plant_press);
				d.reference = rand_q16();
				send_sample(d, 1'b0, '0);
			end
		end

		no_gaps = 1'b0;
		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
src/mrac_pkg.sv
src/mrac_mac.sv
src/mrac_adaptive_controller_top.sv
tb/sv/tb.sv
